@@ rtl/core/oca_pkg.sv @@
// Shared types and constants for the overlap column allocator.
// Holds the scan record that travels along the cell chain and the write beat.
// No dependencies.
package oca_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int TIME_W = 7;
  localparam logic [TIME_W-1:0] QUARTERS_PER_DAY = TIME_W'(24 * 4);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // Running result of the scan, updated by each cell in turn.
  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] min_end;
    logic [COL_W-1:0]  min_idx;
    logic [CNT_W-1:0]  cur_len;
    logic [COL_W-1:0]  cur_start;
    logic [CNT_W-1:0]  best;
    logic [COL_W-1:0]  best_start;
  } rec_t;

  // Marks a range of columns with a new end time.
  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  col;
    logic [CNT_W-1:0]  span;
    logic [TIME_W-1:0] stop;
  } wr_t;

endpackage

@@ rtl/core/oca_cell.sv @@
// One column of the allocator: holds that column's end time.
// Updates the passing scan record and registers it for its right neighbor.
// Depends on oca_pkg.
module oca_cell
  import oca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic [COL_W-1:0] idx,
  input  rec_t             rec_in,
  input  wr_t              wr,
  output rec_t             rec_out
);

  logic [TIME_W-1:0] end_time;
  rec_t              rec_next;
  logic              active;
  logic              free;
  logic [CNT_W-1:0]  run_len;
  logic [COL_W-1:0]  run_start;
  logic [CNT_W:0]    lim;
  logic              in_rng;

  assign active = CNT_W'(idx) < rec_in.n;
  assign lim = (CNT_W + 1)'(wr.col) + (CNT_W + 1)'(wr.span);
  assign in_rng = (idx >= wr.col) && ((CNT_W + 1)'(idx) < lim);

  always_comb begin
    rec_next = rec_in;
    free = active && (end_time <= rec_in.start);
    run_len = rec_in.cur_len + CNT_W'(1);
    run_start = (rec_in.cur_len == '0) ? idx : rec_in.cur_start;
    if (active && (end_time < rec_in.min_end)) begin
      rec_next.min_end = end_time;
      rec_next.min_idx = idx;
    end
    if (free) begin
      rec_next.cur_len = run_len;
      rec_next.cur_start = run_start;
      if (run_len > rec_in.best) begin
        rec_next.best = run_len;
        rec_next.best_start = run_start;
      end
    end else begin
      rec_next.cur_len = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      end_time <= '0;
    end else if (wr.en && in_rng) begin
      end_time <= wr.stop;
    end
  end

  always_ff @(posedge clk) begin
    rec_out <= rec_next;
  end

endmodule

@@ rtl/core/oca_chain.sv @@
// Row of column cells; the scan record moves one cell per clock.
// Write beats reach all cells at once.
// Depends on oca_pkg and oca_cell.
module oca_chain
  import oca_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  rec_t scan_in,
  input  wr_t  wr,
  output rec_t scan_out
);

  rec_t link [MAX_COLUMNS+1];

  assign link[0] = scan_in;
  assign scan_out = link[MAX_COLUMNS];

  for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
    oca_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .idx     (COL_W'(i)),
      .rec_in  (link[i]),
      .wr      (wr),
      .rec_out (link[i+1])
    );
  end

endmodule

@@ rtl/core/overlap_column_allocator.sv @@
// Top level of the overlap column allocator: control sequencer and result registers.
// Depends on oca_pkg and oca_chain.
//
//   Channel  | Handshake            | Beat contents
//   ---------+----------------------+---------------------------------------------
//   input    | start, busy          | first_of_day, start_quarter, end_quarter
//   result   | done (one cycle)     | column, column_span, column_count, overflow
//
// Every interval passes from the accepting edge through the scan state, in which the
// scan record walks the cell chain one cell per clock, and the decide state, which
// decides the placement and marks the chosen columns, on to the registered done beat.
// A new interval can be accepted in the cycle that shows done.
// Reset is synchronous and active high; it empties the table to one column ending
// at quarter zero. The receiver cannot stall, so a result beat lasts one cycle.
module overlap_column_allocator
  import oca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              first_of_day,
  input  logic [TIME_W-1:0] start_quarter,
  input  logic [TIME_W-1:0] end_quarter,
  output logic              done,
  output logic [COL_W-1:0]  column,
  output logic [CNT_W-1:0]  column_span,
  output logic [CNT_W-1:0]  column_count,
  output logic              overflow
);

  state_t            state;
  state_t            state_next;
  logic [COL_W-1:0]  scan_cnt;
  logic [TIME_W-1:0] start_q;
  logic [TIME_W-1:0] stop_q;
  logic [CNT_W-1:0]  count;
  logic [COL_W-1:0]  chosen;
  logic              accept;
  logic              clear;
  rec_t              scan_in;
  rec_t              scan_out;
  wr_t               wr;

  // Decision signals, valid in the decide cycle.
  logic              need_new;
  logic              full;
  logic              ovf_next;
  logic [COL_W-1:0]  col_next;
  logic [CNT_W-1:0]  span_next;
  logic [CNT_W-1:0]  count_next;
  logic [COL_W-1:0]  chosen_next;

  assign accept = start && !busy;
  assign clear = accept && first_of_day;

  // The record entering the first cell carries the search seeds: no earlier end
  // than the day end, the previous chosen column as fallback, and a best run of one.
  always_comb begin
    scan_in.n = count;
    scan_in.start = start_q;
    scan_in.min_end = QUARTERS_PER_DAY;
    scan_in.min_idx = chosen;
    scan_in.cur_len = '0;
    scan_in.cur_start = '0;
    scan_in.best = CNT_W'(1);
    scan_in.best_start = '0;
  end

  oca_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear),
    .scan_in  (scan_in),
    .wr       (wr),
    .scan_out (scan_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, and the placement decision taken from the record that left the
  // last cell.
  always_comb begin
    state_next = state;
    busy = 1'b1;
    need_new = start_q < scan_out.min_end;
    full = count == CNT_W'(MAX_COLUMNS);
    ovf_next = 1'b0;
    col_next = '0;
    span_next = '0;
    count_next = count;
    chosen_next = scan_out.min_idx;
    wr = '0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == COL_W'(MAX_COLUMNS - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
        if (need_new) begin
          if (full) begin
            // Table full: nothing placed, table untouched.
            ovf_next = 1'b1;
          end else begin
            col_next = count[COL_W-1:0];
            span_next = CNT_W'(1);
            count_next = count + CNT_W'(1);
          end
        end else begin
          // A run of two or more free columns beats the earliest-ending column.
          if (scan_out.best > CNT_W'(1)) begin
            chosen_next = scan_out.best_start;
          end
          col_next = chosen_next;
          span_next = scan_out.best;
        end
        wr.en = !ovf_next;
        wr.col = col_next;
        wr.span = span_next;
        wr.stop = stop_q;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      count <= CNT_W'(1);
      chosen <= '0;
      done <= 1'b0;
    end else begin
      done <= state == ST_DECIDE;
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + COL_W'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (clear) begin
        count <= CNT_W'(1);
        chosen <= '0;
      end else if (state == ST_DECIDE) begin
        count <= count_next;
        chosen <= chosen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_q <= start_quarter;
      stop_q <= end_quarter;
    end
    if (state == ST_DECIDE) begin
      column <= col_next;
      column_span <= span_next;
      column_count <= count_next;
      overflow <= ovf_next;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("result beat while an interval is still in work");

  a_overflow_result: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (column_span == '0 && column_count == CNT_W'(MAX_COLUMNS)))
    else $error("overflow beat with a placed span or a table that is not full");

  a_placed_span: assert property (@(posedge clk) disable iff (rst)
    (done && !overflow) |-> (column_span != '0))
    else $error("placed interval without any column");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted interval did not make the block busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNT_W'(MAX_COLUMNS)))
    else $error("column count out of range");
`endif

endmodule

@@ tb/overlap_column_allocator_test.sv @@
// Self-checking test of overlap_column_allocator: a directed table, then random days of intervals.
// Each result beat is compared with a built-in column packing predictor.
// Depends on oca_pkg and the overlap_column_allocator RTL.
module overlap_column_allocator_test;
  import oca_pkg::*;

  // One placement decision, as the result ports show it.
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } placement_t;

  // One row of the directed table. Rows marked pinned carry a hand-written placement.
  typedef struct {
    logic              fod;
    logic [TIME_W-1:0] from_q;
    logic [TIME_W-1:0] to_q;
    bit                pinned;
    placement_t        want;
  } interval_row_t;

  localparam int QUIET_LIMIT = 1000;
  localparam int ITEM_GOAL = 1750;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              first_of_day = 1'b0;
  logic [TIME_W-1:0] start_quarter = '0;
  logic [TIME_W-1:0] end_quarter = '0;
  logic              done;
  logic [COL_W-1:0]  column;
  logic [CNT_W-1:0]  column_span;
  logic [CNT_W-1:0]  column_count;
  logic              overflow;

  // Predictor copy of the column table.
  logic [TIME_W-1:0] col_end [MAX_COLUMNS];
  logic [CNT_W-1:0]  open_cols;
  logic [COL_W-1:0]  last_pick;

  placement_t    awaited_placements[$];
  interval_row_t directed_rows[$];
  int            mismatches = 0;
  int            intervals_sent = 0;
  int            quiet_cycles = 0;

  overlap_column_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .first_of_day (first_of_day),
    .start_quarter(start_quarter),
    .end_quarter  (end_quarter),
    .done         (done),
    .column       (column),
    .column_span  (column_span),
    .column_count (column_count),
    .overflow     (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Places one interval in the predictor table and returns what the block should report.
  // The earliest-end search only moves the pick on a strictly smaller end below the day end,
  // so a day where every column ends late keeps the pick of an earlier interval.
  function automatic placement_t place_interval(input logic clear_day,
                                                input logic [TIME_W-1:0] from_q,
                                                input logic [TIME_W-1:0] to_q);
    placement_t        res;
    int                n;
    int                run;
    int                widest;
    logic [TIME_W-1:0] earliest;
    res = '0;
    if (clear_day) begin
      foreach (col_end[i]) col_end[i] = '0;
      open_cols = CNT_W'(1);
      last_pick = '0;
    end
    n = (open_cols > MAX_COLUMNS) ? MAX_COLUMNS : open_cols;
    earliest = QUARTERS_PER_DAY;
    for (int j = 0; j < n; j++) begin
      if (col_end[j] < earliest) begin
        earliest = col_end[j];
        last_pick = COL_W'(j);
      end
    end
    if (from_q < earliest) begin
      // Every column is still occupied: open a new one, or flag a full table.
      if (n >= MAX_COLUMNS) begin
        res.overflow = 1'b1;
      end else begin
        res.column = COL_W'(n);
        res.span = CNT_W'(1);
        col_end[n] = to_q;
        open_cols = CNT_W'(n + 1);
      end
    end else begin
      // Widest run of free columns; the first run found wins a tie.
      widest = 1;
      for (int j = 0; j < n; j++) begin
        if (col_end[j] <= from_q) begin
          run = 1;
          for (int k = j + 1; k < n && col_end[k] <= from_q; k++) run++;
          if (run > widest) begin
            widest = run;
            last_pick = COL_W'(j);
          end
        end
      end
      res.column = last_pick;
      res.span = CNT_W'(widest);
      for (int j = last_pick; j < last_pick + widest && j < MAX_COLUMNS; j++) col_end[j] = to_q;
    end
    res.count = open_cols;
    return res;
  endfunction

  function automatic void add_row(input logic fod, input int from_q, input int to_q,
                                  input bit pinned, input placement_t want);
    interval_row_t row;
    row.fod = fod;
    row.from_q = TIME_W'(from_q);
    row.to_q = TIME_W'(to_q);
    row.pinned = pinned;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Sends one interval beat. Before the beat, each cycle the sender leaves start low with a
  // chance of idle_pct percent.
  // Called and returning at a falling edge.
  task automatic send_interval(input logic fod, input logic [TIME_W-1:0] from_q,
                               input logic [TIME_W-1:0] to_q, input bit pinned,
                               input placement_t want, input int idle_pct);
    placement_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    first_of_day <= fod;
    start_quarter <= from_q;
    end_quarter <= to_q;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = place_interval(fod, from_q, to_q);
    awaited_placements.push_back(pinned ? want : predicted);
    intervals_sent++;
    @(negedge clk);
  endtask

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Result checking and the watchdog. Outputs are read in the active region of the rising
  // edge, so they still hold the values of the cycle that this edge ends.
  always @(posedge clk) begin
    placement_t exp_p;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (done) begin
        if (awaited_placements.size() == 0) begin
          $display("%0t: unexpected result beat, column %0d span %0d count %0d overflow %0d",
                   $time, column, column_span, column_count, overflow);
          mismatches++;
        end else begin
          exp_p = awaited_placements.pop_front();
          compare_field("column", exp_p.column, column);
          compare_field("column_span", exp_p.span, column_span);
          compare_field("column_count", exp_p.count, column_count);
          compare_field("overflow", exp_p.overflow, overflow);
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int          idle_pct;
    int          day_len;
    int          step_max;
    int          t;
    int          to_q;
    logic        fod;
    logic [6:0]  from_q;

    foreach (col_end[i]) col_end[i] = '0;
    open_cols = CNT_W'(1);
    last_pick = '0;

    // Directed table. Pinned rows: a fresh day, then a second column, then columns up to
    // the full table, an overflow, one interval that takes all sixteen columns, and an
    // overflow when every column ends past the day end.
    add_row(1'b1, 0, 8, 1'b1, '{4'd0, 5'd1, 5'd1, 1'b0});
    add_row(1'b0, 0, 4, 1'b1, '{4'd1, 5'd1, 5'd2, 1'b0});
    for (int k = 2; k < MAX_COLUMNS; k++)
      add_row(1'b0, 0, 96, 1'b1, '{COL_W'(k), 5'd1, CNT_W'(k + 1), 1'b0});
    add_row(1'b0, 1, 96, 1'b1, '{4'd0, 5'd0, 5'd16, 1'b1});
    add_row(1'b0, 127, 127, 1'b1, '{4'd0, 5'd16, 5'd16, 1'b0});
    add_row(1'b0, 5, 100, 1'b1, '{4'd0, 5'd0, 5'd16, 1'b1});
    // Predicted rows: the pick moves to column one, then every column ends at or past the
    // day end and a start past the day end falls back to the kept pick.
    add_row(1'b1, 0, 96, 1'b0, '0);
    add_row(1'b0, 10, 20, 1'b0, '0);
    add_row(1'b0, 20, 100, 1'b0, '0);
    add_row(1'b0, 98, 3, 1'b0, '0);
    add_row(1'b1, 95, 0, 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_interval(directed_rows[i].fod, directed_rows[i].from_q, directed_rows[i].to_q,
                    directed_rows[i].pinned, directed_rows[i].want, 25);

    // Random days: mostly well-formed days in start order with a first-of-day beat at the
    // head, with about one beat in ten replaced by noise that ignores both rules.
    while (intervals_sent < ITEM_GOAL + directed_rows.size()) begin
      day_len = $urandom_range(1, 36);
      step_max = $urandom_range(0, 4);
      t = $urandom_range(0, 40);
      for (int i = 0; i < day_len; i++) begin
        if (intervals_sent < 600) idle_pct = 25;
        else if (intervals_sent < 1200) idle_pct = 65;
        else idle_pct = 0;
        if ($urandom_range(0, 9) == 0) begin
          fod = 1'($urandom_range(0, 1));
          from_q = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom_range(96, 127))
                                               : TIME_W'($urandom_range(0, 95));
          to_q = $urandom_range(0, 127);
        end else begin
          fod = (i == 0);
          t = t + $urandom_range(0, step_max);
          if (t > 95) t = 95;
          from_q = TIME_W'(t);
          if ($urandom_range(0, 3) == 0) to_q = t + $urandom_range(0, 96 - t);
          else to_q = t + $urandom_range(0, 8);
          if (to_q > 96) to_q = 96;
        end
        send_interval(fod, from_q, TIME_W'(to_q), 1'b0, '0, idle_pct);
      end
    end
    start <= 1'b0;

    while (awaited_placements.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ overlap_column_allocator.f @@
rtl/core/oca_pkg.sv
rtl/core/oca_cell.sv
rtl/core/oca_chain.sv
rtl/core/overlap_column_allocator.sv
tb/overlap_column_allocator_test.sv
